// ----- rtl/mvcc_pkg.sv -----
// mvcc_pkg: state, operation and status codes for the version chain store
// depends on nothing; imported by mvcc_version_chain_store
package mvcc_pkg;

	// controller states, one-hot
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_FREE = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	// operation codes on func
	typedef enum logic [1:0] {
		F_CREATE = 2'd0,
		F_READ   = 2'd1,
		F_UPDATE = 2'd2,
		F_FINAL  = 2'd3
	} func_t;

	// status codes on status
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_INVALID   = 2'd2
	} status_t;

endpackage

// ----- rtl/mvcc_version_chain_store.sv -----
// mvcc_version_chain_store: multi-version record store over one entry memory
// depends on mvcc_pkg (state, operation and status codes)
// sequence: after the accept cycle the block evaluates the entry read (S_EVAL), then raises
//   done (S_DONE); a pushing update passes S_FREE too, a read stays in S_EVAL per entry visited
// a new transaction is taken in the cycle done is high; because of the registered memory
//   read ahead of each evaluation, none is taken before the last one is through
// reset: control and free list come up at once, no clearing pass; unused entries
//   are chained by an allocation mark, entry contents are not reset
// the receiver cannot stall: done is high for one cycle only
module mvcc_version_chain_store
	import mvcc_pkg::*;
#(
	parameter int POOL_BITS   = 18,
	parameter int DATA_BITS   = 32,
	parameter int COMMIT_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             func,
	input  logic [POOL_BITS:0]     head_index,
	input  logic [COMMIT_BITS-1:0] commit_number,
	input  logic [DATA_BITS-1:0]   new_data,
	input  logic                   do_commit,
	output logic                   done,
	output logic [POOL_BITS:0]     result_index,
	output logic                   found,
	output logic [DATA_BITS-1:0]   read_data,
	output logic [1:0]             status
);

	localparam int IDX_W  = POOL_BITS + 1;
	localparam int DEPTH  = 1 << POOL_BITS;
	localparam int DAT_LO = IDX_W + 1;
	localparam int CMT_LO = IDX_W + 1 + DATA_BITS;
	localparam int WORD_W = COMMIT_BITS + DATA_BITS + IDX_W + 1;
	localparam logic [IDX_W-1:0] IDX_NULL = {1'b1, {POOL_BITS{1'b0}}};

	// entry memory: {commit, data, link, dirty}
	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_word_q;
	logic [POOL_BITS-1:0] addr_q;
	logic mem_we;
	logic [POOL_BITS-1:0] mem_wa, mem_ra;
	logic [WORD_W-1:0] mem_wd;

	state_t state_q, state_d;
	func_t func_q, func_d;
	logic [IDX_W-1:0] head_q, head_d, cur_q, cur_d, steps_q, steps_d;
	logic [IDX_W-1:0] free_head_q, free_head_d, wm_q, wm_d;
	logic [COMMIT_BITS-1:0] csn_q, csn_d;
	logic [DATA_BITS-1:0] data_q, data_d;
	logic commit_q, commit_d;
	logic [IDX_W-1:0] res_q, res_d;
	logic found_q, found_d;
	logic [DATA_BITS-1:0] rdata_q, rdata_d;
	status_t status_q, status_d;

	logic accept;
	logic [IDX_W-1:0] in_head, addr_ext, link_v, nxt, fh_ext, wm_alloc;
	logic rd_dirty, fh_null;
	logic [IDX_W-1:0] rd_link;
	logic [DATA_BITS-1:0] rd_data;
	logic [COMMIT_BITS-1:0] rd_commit;
	logic [POOL_BITS-1:0] fh_idx;

	// handshake
	assign busy   = !(state_q == S_IDLE || state_q == S_DONE);
	assign accept = start && !busy;
	assign done   = (state_q == S_DONE);

	assign result_index = res_q;
	assign found        = found_q;
	assign read_data    = rdata_q;
	assign status       = status_q;

	// unpack the entry that was read last cycle
	assign rd_dirty  = rd_word_q[0];
	assign rd_link   = rd_word_q[IDX_W:1];
	assign rd_data   = rd_word_q[DAT_LO +: DATA_BITS];
	assign rd_commit = rd_word_q[CMT_LO +: COMMIT_BITS];

	// entries at or above the allocation mark were never written and link to the next one
	assign addr_ext = {1'b0, addr_q};
	assign link_v   = (addr_ext >= wm_q) ? addr_ext + IDX_W'(1) : rd_link;
	assign nxt      = link_v[POOL_BITS] ? IDX_NULL : link_v;
	assign in_head  = head_index[POOL_BITS] ? IDX_NULL : head_index;

	// free list head and allocation mark update on taking an entry
	assign fh_idx   = free_head_q[POOL_BITS-1:0];
	assign fh_null  = free_head_q[POOL_BITS];
	assign fh_ext   = {1'b0, fh_idx};
	assign wm_alloc = (fh_ext >= wm_q) ? fh_ext + IDX_W'(1) : wm_q;

	// controller and read-modify-write sequencing
	always_comb begin
		state_d     = state_q;
		func_d      = func_q;
		head_d      = head_q;
		cur_d       = cur_q;
		steps_d     = steps_q;
		csn_d       = csn_q;
		data_d      = data_q;
		commit_d    = commit_q;
		free_head_d = free_head_q;
		wm_d        = wm_q;
		res_d       = res_q;
		found_d     = found_q;
		rdata_d     = rdata_q;
		status_d    = status_q;
		mem_we      = 1'b0;
		mem_wa      = addr_q;
		mem_wd      = rd_word_q;
		mem_ra      = addr_q;
		unique case (state_q)
			S_IDLE, S_DONE: begin
				if (accept) begin
					func_d   = func_t'(func);
					head_d   = in_head;
					cur_d    = in_head;
					steps_d  = '0;
					csn_d    = commit_number;
					data_d   = new_data;
					commit_d = do_commit;
					mem_ra   = (func_t'(func) == F_CREATE) ? fh_idx
						: head_index[POOL_BITS-1:0];
					state_d  = S_EVAL;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_EVAL: begin
				res_d    = head_q;
				found_d  = 1'b0;
				rdata_d  = '0;
				status_d = ST_OK;
				state_d  = S_DONE;
				unique case (func_q)
					F_CREATE: begin
						if (fh_null) begin
							status_d = ST_EXHAUSTED;
							res_d    = IDX_NULL;
						end else begin
							mem_we      = 1'b1;
							mem_wa      = fh_idx;
							mem_wd      = {csn_q, data_q, IDX_NULL, 1'b1};
							free_head_d = nxt;
							wm_d        = wm_alloc;
							res_d       = free_head_q;
						end
					end
					F_READ: begin
						// walk the chain, one entry a cycle
						if (cur_q[POOL_BITS] || steps_q == IDX_NULL) begin
							found_d = 1'b0;
						end else if (!rd_dirty && rd_commit <= csn_q) begin
							found_d = 1'b1;
							rdata_d = rd_data;
						end else begin
							cur_d   = nxt;
							steps_d = steps_q + IDX_W'(1);
							mem_ra  = nxt[POOL_BITS-1:0];
							state_d = S_EVAL;
						end
					end
					F_UPDATE: begin
						if (head_q[POOL_BITS]) begin
							status_d = ST_INVALID;
						end else if (rd_dirty) begin
							if (rd_commit != csn_q) begin
								status_d = ST_INVALID;
							end else begin
								mem_we = 1'b1;
								mem_wd = {rd_commit, data_q, rd_link, rd_dirty};
							end
						end else if (rd_commit > csn_q) begin
							status_d = ST_INVALID;
						end else if (fh_null) begin
							status_d = ST_EXHAUSTED;
						end else begin
							// fetch the link of the free entry before pushing
							mem_ra  = fh_idx;
							state_d = S_FREE;
						end
					end
					F_FINAL: begin
						if (head_q[POOL_BITS] || !rd_dirty) begin
							status_d = ST_INVALID;
						end else if (commit_q) begin
							mem_we = 1'b1;
							mem_wd = {csn_q, rd_data, rd_link, 1'b0};
						end else begin
							// abort: unlink the head and return it to the free list
							mem_we      = 1'b1;
							mem_wd      = {rd_commit, rd_data, free_head_q, rd_dirty};
							res_d       = nxt;
							free_head_d = head_q;
						end
					end
					default: status_d = ST_INVALID;
				endcase
			end
			S_FREE: begin
				// push a new dirty head above the clean one
				mem_we      = 1'b1;
				mem_wa      = fh_idx;
				mem_wd      = {csn_q, data_q, head_q, 1'b1};
				free_head_d = nxt;
				wm_d        = wm_alloc;
				res_d       = free_head_q;
				status_d    = ST_OK;
				state_d     = S_DONE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_word_q <= mem[mem_ra];
		addr_q    <= mem_ra;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= '0;
			wm_q        <= '0;
		end else begin
			state_q     <= state_d;
			free_head_q <= free_head_d;
			wm_q        <= wm_d;
		end
	end

	// transaction and result registers
	always_ff @(posedge clk) begin
		func_q   <= func_d;
		head_q   <= head_d;
		cur_q    <= cur_d;
		steps_q  <= steps_d;
		csn_q    <= csn_d;
		data_q   <= data_d;
		commit_q <= commit_d;
		res_q    <= res_d;
		found_q  <= found_d;
		rdata_q  <= rdata_d;
		status_q <= status_d;
	end

	// a result only follows evaluation of an entry
	a_done_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_EVAL || $past(state_q) == S_FREE))
		else $error("result without evaluation");

	// a found version always comes with ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (status == ST_OK))
		else $error("found with error status");

	// free list head is an entry or exactly null
	a_free_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q[POOL_BITS] |-> (free_head_q == IDX_NULL))
		else $error("free list head out of range");

	// allocation mark never passes the pool size
	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		wm_q[POOL_BITS] |-> (wm_q == IDX_NULL))
		else $error("allocation mark out of range");

	// an accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("not busy after accept");

endmodule
